>>> src/aks_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aks_pkg
// Shared constants, codes and AES helper functions for the key-slot engine.
// ----------------------------------------------------------------------------
package aks_pkg;

  localparam int NUM_SLOTS = 64;
  localparam int SLOT_W    = 6;
  localparam int ADDR_W    = 4;

  localparam logic [127:0] SCR_C = 128'h1FF9E9AAC5FE0408024591DC5D52768A;

  localparam logic [2:0] REQ_NKEY  = 3'd0;
  localparam logic [2:0] REQ_KEYX  = 3'd1;
  localparam logic [2:0] REQ_KEYY  = 3'd2;
  localparam logic [2:0] REQ_CLOAD = 3'd3;
  localparam logic [2:0] REQ_CADV  = 3'd4;
  localparam logic [2:0] REQ_CRYPT = 3'd5;

  localparam logic [1:0] REG_SLOT = 2'd0;
  localparam logic [1:0] REG_MODE = 2'd1;
  localparam logic [1:0] REG_DIR  = 2'd2;

  typedef logic [7:0] sbox_tbl_t [256];

  localparam sbox_tbl_t SBOX = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic sbox_tbl_t mk_inv_sbox();
    sbox_tbl_t t;
    for (int i = 0; i < 256; i++) t[SBOX[i]] = 8'(i);
    return t;
  endfunction

  localparam sbox_tbl_t INV_SBOX = mk_inv_sbox();

  function automatic logic [7:0] rcon(input logic [3:0] r);
    case (r)
      4'd1:    return 8'h01;
      4'd2:    return 8'h02;
      4'd3:    return 8'h04;
      4'd4:    return 8'h08;
      4'd5:    return 8'h10;
      4'd6:    return 8'h20;
      4'd7:    return 8'h40;
      4'd8:    return 8'h80;
      4'd9:    return 8'h1b;
      4'd10:   return 8'h36;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of the block sits at [127-8i -: 8]
  function automatic logic [127:0] shift_rows(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++)
      for (int i = 0; i < 4; i++)
        t[127-8*(c*4+i) -: 8] = s[127-8*((((c+i)&3)*4)+i) -: 8];
    return t;
  endfunction

  function automatic logic [127:0] inv_shift_rows(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++)
      for (int i = 0; i < 4; i++)
        t[127-8*((((c+i)&3)*4)+i) -: 8] = s[127-8*(c*4+i) -: 8];
    return t;
  endfunction

  function automatic logic [127:0] mix_cols(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127-32*c -: 8];
      a1 = s[119-32*c -: 8];
      a2 = s[111-32*c -: 8];
      a3 = s[103-32*c -: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      t[127-32*c -: 8] = a0 ^ al ^ xt(a0 ^ a1);
      t[119-32*c -: 8] = a1 ^ al ^ xt(a1 ^ a2);
      t[111-32*c -: 8] = a2 ^ al ^ xt(a2 ^ a3);
      t[103-32*c -: 8] = a3 ^ al ^ xt(a3 ^ a0);
    end
    return t;
  endfunction

  function automatic logic [7:0] gm(input logic [7:0] a, input logic [3:0] m);
    logic [7:0] x1, x2, x3;
    x1 = xt(a);
    x2 = xt(x1);
    x3 = xt(x2);
    return (m[3] ? x3 : 8'h00) ^ (m[2] ? x2 : 8'h00) ^ (m[1] ? x1 : 8'h00) ^
           (m[0] ? a : 8'h00);
  endfunction

  function automatic logic [127:0] inv_mix_cols(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127-32*c -: 8];
      a1 = s[119-32*c -: 8];
      a2 = s[111-32*c -: 8];
      a3 = s[103-32*c -: 8];
      t[127-32*c -: 8] = gm(a0,4'd14) ^ gm(a1,4'd11) ^ gm(a2,4'd13) ^ gm(a3,4'd9);
      t[119-32*c -: 8] = gm(a0,4'd9) ^ gm(a1,4'd14) ^ gm(a2,4'd11) ^ gm(a3,4'd13);
      t[111-32*c -: 8] = gm(a0,4'd13) ^ gm(a1,4'd9) ^ gm(a2,4'd14) ^ gm(a3,4'd11);
      t[103-32*c -: 8] = gm(a0,4'd11) ^ gm(a1,4'd13) ^ gm(a2,4'd9) ^ gm(a3,4'd14);
    end
    return t;
  endfunction

  function automatic logic [31:0] key_t_word(input logic [31:0] w, input logic [7:0] rc);
    return {SBOX[w[23:16]] ^ rc, SBOX[w[15:8]], SBOX[w[7:0]], SBOX[w[31:24]]};
  endfunction

  function automatic logic [127:0] key_next(input logic [127:0] p, input logic [7:0] rc);
    logic [31:0] k0, k1, k2, k3;
    k0 = p[127:96] ^ key_t_word(p[31:0], rc);
    k1 = p[95:64] ^ k0;
    k2 = p[63:32] ^ k1;
    k3 = p[31:0] ^ k2;
    return {k0, k1, k2, k3};
  endfunction

  function automatic logic [127:0] key_prev(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] p0, p1, p2, p3;
    p3 = k[31:0] ^ k[63:32];
    p2 = k[63:32] ^ k[95:64];
    p1 = k[95:64] ^ k[127:96];
    p0 = k[127:96] ^ key_t_word(p3, rc);
    return {p0, p1, p2, p3};
  endfunction

endpackage

>>> src/aks_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aks_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module aks_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> src/aes_keyslot_engine_with_scrambler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_keyslot_engine_with_scrambler
// AES-128 ECB/CTR engine with 64 key slots and a key-Y scrambler.
//
// Input words (in_*) carry a request type in tuser: key writes, counter load or
// advance, or a crypt block. Key, counter and ignored requests complete on
// acceptance; a key Y write runs the scrambler via S_SCR_RD and S_SCR_WR. A
// crypt block produces one out_* word. The state passes byte-serially through
// a single S-box shift stage (S_SUB) plus one mix/key step (S_MIX) per round,
// 10 rounds in all. Blocks pass S_KEY_RD, S_KEY_LD, the rounds and S_DONE;
// decrypt adds forward key expansion (S_KEXP) before the first round.
// One item is in flight at a time; the next is accepted once the result has
// moved into the output register, which holds it while out_tready is low.
// The config port (APB style) sets active slot (0x0), mode (0x4: 0 ECB, 1 CTR)
// and direction (0x8: 0 decrypt, 1 encrypt); write it only while idle.
// Reset (synchronous, rst_n low) clears control and config registers, the counter and slot valid
// bits; unwritten slots read as all-zero keys.
// ----------------------------------------------------------------------------
module aes_keyslot_engine_with_scrambler (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [135:0] in_tdata,   // slot[5:0], data_high[69:6], data_low[133:70]
  input  logic [2:0]   in_tuser,   // req_type[2:0]
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // result_high[63:0], result_low[127:64]
  output logic         out_tlast,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [aks_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCR_RD = 4'd1;
  localparam logic [3:0] S_SCR_WR = 4'd2;
  localparam logic [3:0] S_KEY_RD = 4'd3;
  localparam logic [3:0] S_KEY_LD = 4'd4;
  localparam logic [3:0] S_KEXP   = 4'd5;
  localparam logic [3:0] S_SUB    = 4'd6;
  localparam logic [3:0] S_MIX    = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  localparam int SW = aks_pkg::SLOT_W;

  logic [3:0]    state_r;
  logic [SW-1:0] act_slot_r;
  logic          mode_r, dir_r;
  logic [127:0]  ctr_r;
  logic [SW-1:0] slot_r;
  logic [127:0]  data_r;
  logic          last_r;
  logic [127:0]  st_r, key_r;
  logic [3:0]    round_r, cnt_r;
  logic [aks_pkg::NUM_SLOTS-1:0] x_vld_r, nk_vld_r;
  logic          out_valid_r;
  logic [127:0]  out_data_r;
  logic          out_last_r;

  logic [2:0]    in_type;
  logic [SW-1:0] in_slot;
  logic [127:0]  in_data;
  logic          in_acc, slot_ok;
  logic          cfg_wr;
  logic [1:0]    cfg_idx;

  logic          x_we, nk_we;
  logic [SW-1:0] nk_waddr, nk_raddr;
  logic [127:0]  nk_wdata, x_rdata, nk_rdata;
  logic [127:0]  x_key, scr_v, scr_nk, ld_key, ld_blk, enc_t, dec_t, kn, kp, res;
  logic [7:0]    sb_in;
  logic          out_load;

  assign in_type = in_tuser;
  assign in_slot = in_tdata[5:0];
  assign in_data = {in_tdata[69:6], in_tdata[133:70]};
  assign in_tready = (state_r == S_IDLE);
  assign in_acc = in_tvalid && in_tready;
  assign slot_ok = ({1'b0, in_slot} < (SW+1)'(aks_pkg::NUM_SLOTS));

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx = cfg_paddr[3:2];

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[1:0] == 2'b00) begin
      case (cfg_idx)
        aks_pkg::REG_SLOT: cfg_prdata = 32'(act_slot_r);
        aks_pkg::REG_MODE: cfg_prdata = 32'(mode_r);
        aks_pkg::REG_DIR:  cfg_prdata = 32'(dir_r);
        default:           cfg_prdata = '0;
      endcase
    end
  end

  // scrambler
  assign x_key  = x_vld_r[slot_r] ? x_rdata : '0;
  assign scr_v  = {x_key[125:0], x_key[127:126]} ^ data_r;
  assign scr_nk = scr_v + aks_pkg::SCR_C;

  assign x_we     = in_acc && (in_type == aks_pkg::REQ_KEYX) && slot_ok;
  assign nk_we    = (in_acc && (in_type == aks_pkg::REQ_NKEY) && slot_ok) ||
                    (state_r == S_SCR_WR);
  assign nk_waddr = (state_r == S_SCR_WR) ? slot_r : in_slot;
  assign nk_wdata = (state_r == S_SCR_WR) ? {scr_nk[40:0], scr_nk[127:41]} : in_data;
  assign nk_raddr = act_slot_r;

  aks_ram #(.WIDTH(128), .DEPTH(aks_pkg::NUM_SLOTS)) u_x_ram (
    .clk(clk), .we(x_we), .waddr(in_slot), .wdata(in_data),
    .raddr(slot_r), .rdata(x_rdata)
  );

  aks_ram #(.WIDTH(128), .DEPTH(aks_pkg::NUM_SLOTS)) u_nk_ram (
    .clk(clk), .we(nk_we), .waddr(nk_waddr), .wdata(nk_wdata),
    .raddr(nk_raddr), .rdata(nk_rdata)
  );

  assign ld_key = nk_vld_r[act_slot_r] ? nk_rdata : '0;
  assign ld_blk = mode_r ? ctr_r : data_r;
  assign sb_in  = st_r[127:120];
  assign kn     = aks_pkg::key_next(key_r, aks_pkg::rcon(4'(cnt_r + 4'd1)));
  assign kp     = aks_pkg::key_prev(key_r, aks_pkg::rcon(4'(round_r + 4'd1)));
  assign enc_t  = (round_r == 4'd10) ? aks_pkg::shift_rows(st_r)
                                     : aks_pkg::mix_cols(aks_pkg::shift_rows(st_r));
  assign dec_t  = aks_pkg::inv_shift_rows(st_r) ^ kp;
  assign res    = mode_r ? (st_r ^ data_r) : st_r;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      act_slot_r  <= '0;
      mode_r      <= 1'b0;
      dir_r       <= 1'b0;
      ctr_r       <= '0;
      x_vld_r     <= '0;
      nk_vld_r    <= '0;
      out_valid_r <= 1'b0;
      round_r     <= '0;
      cnt_r       <= '0;
    end else begin
      if (cfg_wr && (cfg_paddr[1:0] == 2'b00)) begin
        case (cfg_idx)
          aks_pkg::REG_SLOT: begin
            if ({1'b0, cfg_pwdata[SW-1:0]} < (SW+1)'(aks_pkg::NUM_SLOTS)) begin
              act_slot_r <= cfg_pwdata[SW-1:0];
            end
          end
          aks_pkg::REG_MODE: mode_r <= cfg_pwdata[0];
          aks_pkg::REG_DIR:  dir_r  <= cfg_pwdata[0];
          default: ;
        endcase
      end
      if (x_we) begin
        x_vld_r[in_slot] <= 1'b1;
      end
      if (nk_we) begin
        nk_vld_r[nk_waddr] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            case (in_type)
              aks_pkg::REQ_KEYY:  if (slot_ok) state_r <= S_SCR_RD;
              aks_pkg::REQ_CLOAD: ctr_r <= in_data;
              aks_pkg::REQ_CADV:  ctr_r <= ctr_r + {64'd0, in_data[63:0]};
              aks_pkg::REQ_CRYPT: state_r <= S_KEY_RD;
              default: ;
            endcase
          end
        end
        S_SCR_RD: state_r <= S_SCR_WR;
        S_SCR_WR: state_r <= S_IDLE;
        S_KEY_RD: state_r <= S_KEY_LD;
        S_KEY_LD: begin
          cnt_r <= '0;
          if (mode_r || dir_r) begin
            round_r <= 4'd1;
            state_r <= S_SUB;
          end else begin
            state_r <= S_KEXP;
          end
        end
        S_KEXP: begin
          cnt_r <= 4'(cnt_r + 4'd1);
          if (cnt_r == 4'd9) begin
            cnt_r   <= '0;
            round_r <= 4'd9;
            state_r <= S_SUB;
          end
        end
        S_SUB: begin
          cnt_r <= 4'(cnt_r + 4'd1);
          if (cnt_r == 4'd15) begin
            state_r <= S_MIX;
          end
        end
        S_MIX: begin
          cnt_r <= '0;
          if (mode_r || dir_r) begin
            round_r <= 4'(round_r + 4'd1);
            state_r <= (round_r == 4'd10) ? S_DONE : S_SUB;
          end else begin
            round_r <= 4'(round_r - 4'd1);
            state_r <= (round_r == 4'd0) ? S_DONE : S_SUB;
          end
        end
        S_DONE: begin
          if (out_load) begin
            if (mode_r) begin
              ctr_r <= ctr_r + 128'd1;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      slot_r <= in_slot;
      data_r <= in_data;
      last_r <= in_tlast;
    end
    case (state_r)
      S_KEY_LD: begin
        key_r <= ld_key;
        st_r  <= ld_blk ^ ld_key;
        if (!(mode_r || dir_r)) begin
          st_r <= ld_blk;
        end
      end
      S_KEXP: begin
        key_r <= kn;
        if (cnt_r == 4'd9) begin
          st_r <= st_r ^ kn;
        end
      end
      S_SUB: begin
        st_r <= {st_r[119:0],
                 (mode_r || dir_r) ? aks_pkg::SBOX[sb_in] : aks_pkg::INV_SBOX[sb_in]};
      end
      S_MIX: begin
        if (mode_r || dir_r) begin
          key_r <= aks_pkg::key_next(key_r, aks_pkg::rcon(round_r));
          st_r  <= enc_t ^ aks_pkg::key_next(key_r, aks_pkg::rcon(round_r));
        end else begin
          key_r <= kp;
          st_r  <= (round_r == 4'd0) ? dec_t : aks_pkg::inv_mix_cols(dec_t);
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_data_r <= res;
      out_last_r <= last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_data_r[63:0], out_data_r[127:64]};
  assign out_tlast  = out_last_r;

endmodule
